// File: sv/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types, sizes and codes for the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

    // Number of entries the list store can hold.
    localparam int CAPACITY  = 32;
    // Address width of the list store.
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Width of a count that can hold CAPACITY itself.
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    // Fixed field widths of the interface.
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 6;
    localparam int DATA_W    = 32;
    // Width used to compare a position against the count.
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [DATA_W-1:0] value_t;

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
        logic [POS_W-1:0]   position;
    } in_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 found;
        logic [CNT_OUT_W-1:0] entry_count;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a command and set up the walk
        logic issue;   // read one entry and step the walk pointer
        logic finish;  // final write, count update and result capture
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;      // walk pointer has not reached its end
        logic pend;      // a read is in flight whose data is used this cycle
        logic out_free;  // result register can take a new result
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/ordered_list_engine.sv
// Throughput: one command at a time is taken; the walk, one entry a cycle through the
// store's single ports, sets the rate.
// Reset: aresetn is synchronous and active low; it empties the list and drops any
// waiting result. Store contents are not cleared and need not be.
// ----------------------------------------------------------------------------
// ordered_list_engine
// Positional insert, delete and search over a bounded ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire olist_pkg::in_t  s_payload,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output olist_pkg::out_t      m_payload
);

    // The list is kept packed from index 0 (the head) upwards. An insert
    // walks from the tail down to its position, copying each entry one place
    // up, and then writes the new value into the gap. A delete walks from its
    // position up to the tail, copying each entry one place down. A search
    // reads every held entry and compares it with the key in the cycle after.
    //
    // Each read issued by the walk returns its data in the next cycle, and that
    // data is written back (or compared) in the same cycle as the next read
    // is issued, so the walk runs at one entry per cycle. The controller only
    // finishes once the final copy has landed.
    //
    // The result sits in its own register, so the next transfer on the input
    // side is taken while an earlier result is still waiting to be taken.

    olist_pkg::ctrl_cmd_t cmd;
    olist_pkg::dp_stat_t  stat;

    olist_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    olist_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

`ifndef SYNTH
    // The controller issues at most one command to the datapath per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.issue, cmd.finish}))
        else $error("olist: more than one datapath command in a cycle");

    // The final write must never collide with a copy still in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !stat.pend)
        else $error("olist: finish while a copy is pending");

    // A command occupies the engine for at least the cycle after it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("olist: input taken again straight after a transfer");

    // A found key only ever comes with a successful status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.found) |-> (m_payload.status == olist_pkg::STAT_DONE))
        else $error("olist: found flag set on a failed command");
`endif

endmodule

`default_nettype wire

// File: sv/olist_ctrl.sv
// ----------------------------------------------------------------------------
// olist_ctrl
// Controller state machine for the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire olist_pkg::dp_stat_t   stat,
    output olist_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_PLACE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (stat.more) begin
                    cmd.issue = 1'b1;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                // Wait for the last shifted entry to land and for room in
                // the result register.
                if (!stat.pend && stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/olist_dp.sv
// ----------------------------------------------------------------------------
// olist_dp
// Datapath of the ordered list engine: list store, walk pointer and result.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire olist_pkg::in_t       s_payload,
    input  wire olist_pkg::ctrl_cmd_t cmd,
    output olist_pkg::dp_stat_t       stat,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output olist_pkg::out_t           m_payload
);

    // List store: one write port, one registered read port.
    olist_pkg::value_t mem [olist_pkg::CAPACITY];
    olist_pkg::value_t rdata_reg;

    logic [1:0]          op_reg, op_next;
    olist_pkg::value_t   key_reg, key_next;
    olist_pkg::cnt_t     ptr_reg, ptr_next;
    olist_pkg::cnt_t     end_reg, end_next;
    olist_pkg::cnt_t     len_reg, len_next;
    logic                pend_reg, pend_next;
    olist_pkg::idx_t     wa_reg, wa_next;
    logic                found_reg, found_next;
    logic [1:0]          status_reg, status_next;
    logic                place_reg, place_next;
    logic                grow_reg, grow_next;
    logic                shrink_reg, shrink_next;
    logic                m_valid_reg, m_valid_next;
    olist_pkg::out_t     m_payload_reg, m_payload_next;

    logic [olist_pkg::CMP_W-1:0] pos_ext, len_ext, lenm1_ext;
    olist_pkg::cnt_t             rd_ptr;
    olist_pkg::idx_t             rd_addr;
    logic                        mem_we;
    olist_pkg::idx_t             mem_wa;
    olist_pkg::value_t           mem_wd;

    assign pos_ext   = olist_pkg::CMP_W'(s_payload.position);
    assign len_ext   = olist_pkg::CMP_W'(len_reg);
    assign lenm1_ext = len_ext - olist_pkg::CMP_W'(1);

    // Inserts walk downwards and read the entry below; deletes walk upwards
    // and read the entry above; searches read the entry at the pointer.
    always_comb begin
        case (op_reg)
            olist_pkg::CMD_INSERT: rd_ptr = ptr_reg - olist_pkg::CNT_W'(1);
            olist_pkg::CMD_DELETE: rd_ptr = ptr_reg + olist_pkg::CNT_W'(1);
            default:               rd_ptr = ptr_reg;
        endcase
    end
    assign rd_addr = rd_ptr[olist_pkg::IDX_W-1:0];

    always_comb begin
        mem_we = 1'b0;
        mem_wa = wa_reg;
        mem_wd = rdata_reg;
        if (pend_reg && op_reg != olist_pkg::CMD_SEARCH) begin
            mem_we = 1'b1;
        end else if (cmd.finish && place_reg) begin
            mem_we = 1'b1;
            mem_wa = end_reg[olist_pkg::IDX_W-1:0];
            mem_wd = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.issue) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        len_next       = len_reg;
        pend_next      = cmd.issue;
        wa_next        = wa_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        place_next     = place_reg;
        grow_next      = grow_reg;
        shrink_next    = shrink_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.load) begin
            op_next     = s_payload.cmd;
            key_next    = s_payload.value;
            found_next  = 1'b0;
            status_next = olist_pkg::STAT_DONE;
            place_next  = 1'b0;
            grow_next   = 1'b0;
            shrink_next = 1'b0;
            ptr_next    = '0;
            end_next    = '0;
            case (s_payload.cmd)
                olist_pkg::CMD_INSERT: begin
                    ptr_next = len_reg;
                    end_next = len_reg;
                    if (len_reg == olist_pkg::CNT_W'(olist_pkg::CAPACITY)) begin
                        status_next = olist_pkg::STAT_FULL;
                    end else begin
                        place_next = 1'b1;
                        grow_next  = 1'b1;
                        if (pos_ext < len_ext) begin
                            end_next = olist_pkg::CNT_W'(pos_ext);
                        end
                    end
                end
                olist_pkg::CMD_DELETE: begin
                    if (len_reg == '0) begin
                        status_next = olist_pkg::STAT_EMPTY;
                    end else begin
                        shrink_next = 1'b1;
                        end_next    = len_reg - olist_pkg::CNT_W'(1);
                        if (pos_ext < lenm1_ext) begin
                            ptr_next = olist_pkg::CNT_W'(pos_ext);
                        end else begin
                            ptr_next = len_reg - olist_pkg::CNT_W'(1);
                        end
                    end
                end
                olist_pkg::CMD_SEARCH: begin
                    end_next = len_reg;
                end
                default: begin
                end
            endcase
        end

        if (cmd.issue) begin
            wa_next = ptr_reg[olist_pkg::IDX_W-1:0];
            if (op_reg == olist_pkg::CMD_INSERT) begin
                ptr_next = ptr_reg - olist_pkg::CNT_W'(1);
            end else begin
                ptr_next = ptr_reg + olist_pkg::CNT_W'(1);
            end
        end

        if (pend_reg && op_reg == olist_pkg::CMD_SEARCH && rdata_reg == key_reg) begin
            found_next = 1'b1;
        end

        if (cmd.finish) begin
            if (grow_reg) begin
                len_next = len_reg + olist_pkg::CNT_W'(1);
            end else if (shrink_reg) begin
                len_next = len_reg - olist_pkg::CNT_W'(1);
            end
            m_payload_next.status      = status_reg;
            m_payload_next.found       = found_reg;
            m_payload_next.entry_count = olist_pkg::CNT_OUT_W'(len_next);
            m_valid_next               = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        wa_reg        <= wa_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        place_reg     <= place_next;
        grow_reg      <= grow_next;
        shrink_reg    <= shrink_next;
        m_payload_reg <= m_payload_next;
    end

    assign stat.more     = (ptr_reg != end_reg);
    assign stat.pend     = pend_reg;
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_payload     = m_payload_reg;

endmodule

`default_nettype wire
